// File: rtl/core/iwr_pkg.sv
// ----------------------------------------------------------------------------
// Instruction window retire package
// Shared widths, operation codes, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package iwr_pkg;

  // Window geometry default.
  localparam int unsigned DepthDefault = 128;

  // Field widths.
  localparam int unsigned AddrW    = 48;
  localparam int unsigned OpW      = 2;
  localparam int unsigned RetCntW  = 4;
  localparam int unsigned OccW     = 8;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 4;

  // Stream widths, padded to whole bytes.
  localparam int unsigned SDataW = 56;
  localparam int unsigned MDataW = 16;

  // Largest number of entries one retire may remove.
  localparam logic [RetCntW-1:0] MaxRetire = 4'd8;

  // Operation codes carried on the input tuser.
  localparam logic [OpW-1:0] OP_INSERT   = 2'd0;
  localparam logic [OpW-1:0] OP_RETIRE   = 2'd1;
  localparam logic [OpW-1:0] OP_COMPLETE = 2'd2;
  localparam logic [OpW-1:0] OP_NONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CFG_RETIRE_WIDTH = 1'd0;
  localparam logic [CfgAddrW-1:0] CFG_BLOCK_OFFSET = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the accepted request
    logic insert;    // append the captured entry
    logic ret_step;  // remove the oldest entry
    logic scan_rd;   // read the address of the scanned entry
    logic scan_cmp;  // compare it and move to the next one
    logic load_out;  // capture the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ret_go;    // oldest entry may be retired now
    logic scan_done; // every live entry has been compared
  } status_t;

endpackage

// File: rtl/core/iwr_ctrl.sv
// ----------------------------------------------------------------------------
// Instruction window retire controller
// Sequences one request at a time through insert, retire and completion
// scan, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module iwr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  input  logic [iwr_pkg::OpW-1:0]  s_op_i,
  output logic                     s_ready_o,
  input  logic                     m_ready_i,
  output logic                     m_valid_o,
  input  iwr_pkg::status_t         stat_i,
  output iwr_pkg::cmd_t            cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIns  = 3'd1;
  localparam logic [2:0] StRet  = 3'd2;
  localparam logic [2:0] StCrd  = 3'd3;
  localparam logic [2:0] StCcmp = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       load_out;

  assign s_ready_o = (state_q == StIdle);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  // The result register may be loaded when it is empty or being drained.
  assign load_out = (state_q == StFin) && (!out_valid_q || m_ready_i);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load_in  = accept;
    cmd_o.load_out = load_out;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (s_op_i)
            iwr_pkg::OP_INSERT:   state_d = StIns;
            iwr_pkg::OP_RETIRE:   state_d = StRet;
            iwr_pkg::OP_COMPLETE: state_d = StCrd;
            default:              state_d = StFin;
          endcase
        end
      end
      StIns: begin
        cmd_o.insert = 1'b1;
        state_d      = StFin;
      end
      StRet: begin
        if (stat_i.ret_go) begin
          cmd_o.ret_step = 1'b1;
        end else begin
          state_d = StFin;
        end
      end
      StCrd: begin
        if (stat_i.scan_done) begin
          state_d = StFin;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = StCcmp;
        end
      end
      StCcmp: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = StCrd;
      end
      StFin: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/iwr_datapath.sv
// ----------------------------------------------------------------------------
// Instruction window retire datapath
// Holds the entry address memory, the ready bits, the head and tail
// pointers, the live count, the configuration and the result register.
// ----------------------------------------------------------------------------
module iwr_datapath #(
  parameter int unsigned DEPTH = iwr_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iwr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [iwr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [iwr_pkg::OpW-1:0]       in_op_i,
  input  logic                          in_ready_i,
  input  logic [iwr_pkg::AddrW-1:0]     in_addr_i,
  input  iwr_pkg::cmd_t                 cmd_i,
  output iwr_pkg::status_t              stat_o,
  output logic                          out_accepted_o,
  output logic [iwr_pkg::RetCntW-1:0]   out_retired_o,
  output logic [iwr_pkg::OccW-1:0]      out_occupancy_o,
  output logic                          out_full_o,
  output logic                          out_empty_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned AW   = iwr_pkg::AddrW;
  localparam int unsigned RW   = iwr_pkg::RetCntW;

  // Entry address memory.
  logic [AW-1:0] addr_mem [DEPTH];
  logic [AW-1:0] rdata_q;

  // Window state.
  logic [DEPTH-1:0] ready_q, ready_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;

  // Configuration.
  logic [iwr_pkg::CfgDataW-1:0] rw_q, rw_d;
  logic [iwr_pkg::CfgDataW-1:0] bob_q, bob_d;

  // Captured request and per-request counters.
  logic            acc_q, acc_d;
  logic            in_rdy_q;
  logic [AW-1:0]   in_addr_q;
  logic [RW-1:0]   retired_q, retired_d;
  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic [CntW-1:0] scan_k_q, scan_k_d;

  logic            full;
  logic            empty;
  logic [RW-1:0]   limit;
  logic [AW-1:0]   keep;
  logic            hit;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == IdxW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);
  assign limit = (rw_q > iwr_pkg::MaxRetire) ? iwr_pkg::MaxRetire : rw_q;
  assign keep  = {AW{1'b1}} << bob_q;
  assign hit   = ((rdata_q ^ in_addr_q) & keep) == '0;

  assign stat_o.ret_go    = !empty && (retired_q < limit) && ready_q[head_q];
  assign stat_o.scan_done = (scan_k_q == count_q);

  // Next-state logic for the window and the request counters.
  always_comb begin
    ready_d    = ready_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rw_d       = rw_q;
    bob_d      = bob_q;
    acc_d      = acc_q;
    retired_d  = retired_q;
    scan_idx_d = scan_idx_q;
    scan_k_d   = scan_k_q;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        iwr_pkg::CFG_RETIRE_WIDTH: rw_d  = cfg_wdata_i;
        iwr_pkg::CFG_BLOCK_OFFSET: bob_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.load_in) begin
      acc_d      = (in_op_i == iwr_pkg::OP_INSERT) ? !full : (in_op_i != iwr_pkg::OP_NONE);
      retired_d  = '0;
      scan_idx_d = head_q;
      scan_k_d   = '0;
    end

    if (cmd_i.insert && acc_q) begin
      ready_d[tail_q] = in_rdy_q;
      tail_d          = next_idx(tail_q);
      count_d         = count_q + 1'b1;
    end

    if (cmd_i.ret_step) begin
      head_d    = next_idx(head_q);
      count_d   = count_q - 1'b1;
      retired_d = retired_q + 1'b1;
    end

    if (cmd_i.scan_cmp) begin
      if (hit) begin
        ready_d[scan_idx_q] = 1'b1;
      end
      scan_idx_d = next_idx(scan_idx_q);
      scan_k_d   = scan_k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      rw_q       <= 4'd4;
      bob_q      <= 4'd6;
      acc_q      <= 1'b0;
      retired_q  <= '0;
      scan_idx_q <= '0;
      scan_k_q   <= '0;
    end else begin
      ready_q    <= ready_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      rw_q       <= rw_d;
      bob_q      <= bob_d;
      acc_q      <= acc_d;
      retired_q  <= retired_d;
      scan_idx_q <= scan_idx_d;
      scan_k_q   <= scan_k_d;
    end
  end

  // Captured request payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_rdy_q  <= in_ready_i;
      in_addr_q <= in_addr_i;
    end
  end

  // Address memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && acc_q) begin
      addr_mem[tail_q] <= in_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rdata_q <= addr_mem[scan_idx_q];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_accepted_o  <= acc_q;
      out_retired_o   <= retired_q;
      out_occupancy_o <= iwr_pkg::OccW'(count_q);
      out_full_o      <= full;
      out_empty_o     <= empty;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("live count exceeds the window depth");

  a_retire_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ret_step |-> stat_o.ret_go)
    else $error("retire step issued on an entry that may not retire");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert && acc_q |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted insert did not grow the window by one");

  a_retired_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retired_q <= iwr_pkg::MaxRetire)
    else $error("retire removed more entries than allowed");
`endif

endmodule

// File: rtl/core/instruction_window_retire.sv
// ----------------------------------------------------------------------------
// Instruction window retire
// Circular reorder window with insert, in-order retire and completion by
// address.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation (insert,
// retire, complete), tdata the ready flag and the 48-bit address. Each
// request yields exactly one result on the m_axis channel with the accepted
// flag, the retired count, the occupancy and the full and empty flags.
// One request is worked on at a time. An insert appends the captured
// entry; a retire removes entries at the head pointer, one entry per cycle,
// at most 8 and only while the oldest entry is ready; a completion walks
// the live entries through the single read port of the address memory,
// reading and then comparing each one; the unused operation code goes
// straight to the result. The next request is taken in the cycle after its
// predecessor's result has been loaded into the output register.
// When the receiver stalls, the result waits in the output register; one
// more request may be accepted and worked on, and it holds in its last step
// until the register frees up.
// Reset empties the window and sets retire_width to 4 and block_offset_bits
// to 6; the ready bits clear at once, so no clearing pass is needed.
// Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module instruction_window_retire #(
  parameter int unsigned DEPTH = iwr_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [iwr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [iwr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Request channel.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: entry_ready [0], address [48:1], zero [55:49]
  input  logic [iwr_pkg::SDataW-1:0]    s_axis_tdata,
  // tuser: op [1:0]
  input  logic [iwr_pkg::OpW-1:0]       s_axis_tuser,
  // Result channel.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: accepted [0], retired_count [4:1], occupancy [12:5],
  //        is_full [13], window_empty [14], zero [15]
  output logic [iwr_pkg::MDataW-1:0]    m_axis_tdata
);

  iwr_pkg::cmd_t                cmd;
  iwr_pkg::status_t             stat;
  logic                         out_accepted;
  logic [iwr_pkg::RetCntW-1:0]  out_retired;
  logic [iwr_pkg::OccW-1:0]     out_occupancy;
  logic                         out_full;
  logic                         out_empty;

  iwr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  iwr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_op_i         (s_axis_tuser),
    .in_ready_i      (s_axis_tdata[0]),
    .in_addr_i       (s_axis_tdata[iwr_pkg::AddrW:1]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_accepted_o  (out_accepted),
    .out_retired_o   (out_retired),
    .out_occupancy_o (out_occupancy),
    .out_full_o      (out_full),
    .out_empty_o     (out_empty)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata = {1'b0, out_empty, out_full, out_occupancy, out_retired, out_accepted};

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Instruction window retire testbench
// Drives insert, retire, complete and unused-code requests into the window.
// Every accepted request is run through a cycle-free model of the window,
// and each result is checked field by field against that prediction. Both
// stream sides idle at random. The run covers a full window, a long receiver
// hold-off and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Depth      = iwr_pkg::DepthDefault;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 1000000;

  // Fields of one result, in the order they sit in m_axis_tdata.
  typedef struct packed {
    logic         window_empty;
    logic         is_full;
    logic [7:0]   occupancy;
    logic [3:0]   retired_count;
    logic         accepted;
  } win_status_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [iwr_pkg::CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [iwr_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [iwr_pkg::SDataW-1:0]   s_axis_tdata  = '0;
  logic [iwr_pkg::OpW-1:0]      s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [iwr_pkg::MDataW-1:0]   m_axis_tdata;

  instruction_window_retire i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Model of the window state and its registers.
  logic        win_ready [Depth];
  logic [47:0] win_addr  [Depth];
  int unsigned win_head  = 0;
  int unsigned win_tail  = 0;
  int unsigned win_count = 0;
  logic [3:0]  win_retire_width = 4'd4;
  logic [3:0]  win_offset_bits  = 4'd6;

  win_status_t pending_status[$];
  int unsigned n_mismatch  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit          stall_req   = 1'b0;
  bit          hold_active = 1'b0;
  win_status_t got_status;
  win_status_t want_status;

  initial begin
    for (int i = 0; i < Depth; i++) begin
      win_ready[i] = 1'b0;
    end
  end

  // Applies one request to the model and returns the status it yields.
  function automatic win_status_t window_apply(logic [1:0] op, logic rdy, logic [47:0] a);
    win_status_t res;
    int unsigned lim;
    int unsigned idx;
    logic [47:0] keep;
    res = '0;
    case (op)
      iwr_pkg::OP_INSERT: begin
        if (win_count < Depth) begin
          win_ready[win_tail] = rdy;
          win_addr[win_tail]  = a;
          win_tail            = (win_tail + 1) % Depth;
          win_count++;
          res.accepted = 1'b1;
        end
      end
      iwr_pkg::OP_RETIRE: begin
        lim = (win_retire_width > 4'd8) ? 8 : win_retire_width;
        while (win_count > 0 && res.retired_count < lim && win_ready[win_head]) begin
          win_head = (win_head + 1) % Depth;
          win_count--;
          res.retired_count++;
        end
        res.accepted = 1'b1;
      end
      iwr_pkg::OP_COMPLETE: begin
        keep = ~((48'd1 << win_offset_bits) - 48'd1);
        idx  = win_head;
        for (int k = 0; k < win_count; k++) begin
          if ((win_addr[idx] & keep) == (a & keep)) win_ready[idx] = 1'b1;
          idx = (idx + 1) % Depth;
        end
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    res.occupancy    = win_count[7:0];
    res.is_full      = (win_count == Depth);
    res.window_empty = (win_count == 0);
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Address of a random live entry with some low bits flipped.
  function automatic logic [47:0] live_addr_near(logic [47:0] flip_mask);
    int unsigned idx;
    idx = (win_head + $urandom_range(0, win_count - 1)) % Depth;
    return win_addr[idx] ^ (rand_addr() & flip_mask);
  endfunction

  // Offers one request and predicts its result once it is accepted.
  task automatic send_request(logic [1:0] op, logic rdy, logic [47:0] a);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, a, rdy};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_status.push_back(window_apply(op, rdy, a));
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic drain_window();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [iwr_pkg::CfgAddrW-1:0] idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == iwr_pkg::CFG_RETIRE_WIDTH) win_retire_width = val;
    else win_offset_bits = val;
  endtask

  task automatic set_window_config(logic [3:0] rw, logic [3:0] bo);
    drain_window();
    write_reg(iwr_pkg::CFG_RETIRE_WIDTH, rw);
    write_reg(iwr_pkg::CFG_BLOCK_OFFSET, bo);
  endtask

  // Extremes of the fields, every operation and the special cases.
  task automatic test_directed();
    logic [47:0] a2;
    logic [47:0] a3;
    a2 = 48'hAAAA_AAAA_AAAA;
    a3 = 48'h5555_5555_5555;
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);          // retire on an empty window
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, 48'd0);        // complete on an empty window
    send_request(iwr_pkg::OP_NONE, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_request(iwr_pkg::OP_INSERT, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_INSERT, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_request(iwr_pkg::OP_INSERT, 1'b0, a2);
    send_request(iwr_pkg::OP_INSERT, 1'b0, a3);
    send_request(iwr_pkg::OP_RETIRE, 1'b1, 48'd0);          // oldest entry not ready
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, 48'h3F);       // matches the zero entry
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_COMPLETE, 1'b1, a2 ^ 48'h15);
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, 48'h1234_5678_9ABC);
    send_request(iwr_pkg::OP_NONE, 1'b0, a3);
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, a3 ^ 48'h40);  // differs above the offset
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, a3 ^ 48'h2A);
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    repeat (6) send_request(iwr_pkg::OP_INSERT, 1'b1, rand_addr());
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
  endtask

  // Fills the window, rejects inserts while full, then empties it.
  task automatic test_full_window();
    logic [47:0] base;
    base = rand_addr() & ~48'h1FFF;
    set_window_config(4'd15, 4'd0);
    for (int i = 0; i < Depth; i++) begin
      send_request(iwr_pkg::OP_INSERT, 1'b0, base | (48'(i) << 6));
    end
    send_request(iwr_pkg::OP_INSERT, 1'b1, rand_addr());
    send_request(iwr_pkg::OP_INSERT, 1'b0, rand_addr());
    send_request(iwr_pkg::OP_NONE, 1'b1, rand_addr());
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_COMPLETE, 1'b0, base);         // exact match, oldest only
    send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
    send_request(iwr_pkg::OP_INSERT, 1'b0, base | 48'h1FC0);
    // A wide offset makes one completion mark the whole window ready.
    set_window_config(4'd15, 4'd13);
    send_request(iwr_pkg::OP_COMPLETE, 1'b1, base | 48'h1FFF);
    repeat (17) send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
  endtask

  // The receiver holds off while requests keep coming; then the sender waits.
  task automatic test_backpressure();
    set_window_config(4'd4, 4'd6);
    stall_req = 1'b1;
    while (!hold_active) @(posedge clk_i);
    for (int i = 0; i < 12; i++) begin
      send_request((i % 3 == 2) ? iwr_pkg::OP_RETIRE : iwr_pkg::OP_INSERT, i[0],
                   rand_addr());
    end
    drain_window();
    repeat (8) send_request(iwr_pkg::OP_COMPLETE, 1'b0, live_addr_near(48'h3F));
    repeat (8) send_request(iwr_pkg::OP_RETIRE, 1'b0, 48'd0);
  endtask

  // One random request; occupancy is held at or below cap by turning inserts away.
  task automatic send_random_request(int unsigned ins_pct, int unsigned cap);
    int unsigned r;
    logic [47:0] a;
    r = $urandom_range(0, 99);
    if (r < ins_pct && win_count < cap) begin
      a = (win_count > 0 && $urandom_range(0, 1)) ? live_addr_near(48'hFFFF) : rand_addr();
      send_request(iwr_pkg::OP_INSERT, $urandom_range(0, 99) < 40, a);
    end else if (r < ins_pct + 25 || r < ins_pct) begin
      send_request(iwr_pkg::OP_RETIRE, 1'($urandom_range(0, 1)), rand_addr());
    end else if (r < ins_pct + 29) begin
      send_request(iwr_pkg::OP_NONE, 1'($urandom_range(0, 1)), rand_addr());
    end else begin
      a = (win_count > 0 && $urandom_range(0, 3) != 0) ? live_addr_near(48'hFFFF) : rand_addr();
      send_request(iwr_pkg::OP_COMPLETE, 1'($urandom_range(0, 1)), a);
    end
  endtask

  task automatic run_random_phase(logic [3:0] rw, logic [3:0] bo, int unsigned n,
                                  int unsigned ins_pct, int unsigned cap, bit idle);
    set_window_config(rw, bo);
    idle_on = idle;
    repeat (n) send_random_request(ins_pct, cap);
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    run_random_phase(4'd4, 4'd6, 70, 40, 48, 1'b1);
    run_random_phase(4'd1, 4'd0, 70, 35, 48, 1'b1);
    run_random_phase(4'd8, 4'd12, 70, 45, 48, 1'b1);
    run_random_phase(4'd0, 4'd15, 40, 40, 48, 1'b1);    // retire removes nothing
    run_random_phase(4'd15, 4'd3, 120, 70, Depth, 1'b1); // drives toward full
    run_random_phase(4'd2, 4'd13, 70, 40, 48, 1'b0);    // no idling
    run_random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 60, 40, 48, 1'b1);
  endtask

  // Receiver: random ready with gaps, and one long hold-off on request.
  initial begin : receiver
    int unsigned len;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req   = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        len = gap_len();
        if (len == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (len - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[14:0];
      if (pending_status.size() == 0) begin
        $error("result 0x%04h arrived with no request pending", m_axis_tdata);
        n_mismatch++;
      end else begin
        want_status = pending_status.pop_front();
        if (got_status.accepted !== want_status.accepted) begin
          $error("accepted: expected %0d, got %0d", want_status.accepted, got_status.accepted);
          n_mismatch++;
        end
        if (got_status.retired_count !== want_status.retired_count) begin
          $error("retired_count: expected %0d, got %0d", want_status.retired_count,
                 got_status.retired_count);
          n_mismatch++;
        end
        if (got_status.occupancy !== want_status.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want_status.occupancy,
                 got_status.occupancy);
          n_mismatch++;
        end
        if (got_status.is_full !== want_status.is_full) begin
          $error("is_full: expected %0d, got %0d", want_status.is_full, got_status.is_full);
          n_mismatch++;
        end
        if (got_status.window_empty !== want_status.window_empty) begin
          $error("window_empty: expected %0d, got %0d", want_status.window_empty,
                 got_status.window_empty);
          n_mismatch++;
        end
      end
    end
  end

  // Timeout.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_full_window();
    test_backpressure();
    test_random();
    drain_window();
    repeat (20) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
